@@ src/ssk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssk_pkg
// Shared types and constants for the spaced-seed k-mer filter.
// ----------------------------------------------------------------------------
package ssk_pkg;

  localparam int KMER_W         = 64;
  localparam int KMER_BASES     = 32;
  localparam int MASK_W         = 32;
  localparam int NUM_MASK_REGS  = 6;
  localparam int THR_W          = 3;
  localparam int SEL_W          = 3;
  localparam int HIT_W          = 3;
  localparam int HIT_MAX        = 7;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  // gather unit: four base positions per cycle
  localparam int BASES_PER_STEP = 4;
  localparam int GATHER_STEPS   = KMER_BASES / BASES_PER_STEP;
  localparam int STEP_W         = $clog2(GATHER_STEPS);

  // bit tables are stored as rows of 64 bits
  localparam int ROW_W          = 64;
  localparam int BIT_AW         = $clog2(ROW_W);

  localparam int SEED_WEIGHT_DEF = 10;
  localparam int NUM_SEEDS_DEF   = 6;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MASK_0    = 3'd0,
    REG_MASK_1    = 3'd1,
    REG_MASK_2    = 3'd2,
    REG_MASK_3    = 3'd3,
    REG_MASK_4    = 3'd4,
    REG_MASK_5    = 3'd5,
    REG_THRESHOLD = 3'd6
  } reg_idx_e;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic [KMER_W-1:0] kmer;
    logic [SEL_W-1:0]  table_select;
  } kmer_item_t;

  typedef struct packed {
    logic [HIT_W-1:0] hit_count;
    logic             present;
  } hit_result_t;

endpackage

@@ src/ssk_seed_gather.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssk_seed_gather
// Compacts the masked 2-bit symbols of a k-mer into one table index per
// seed, scanning four base positions per cycle, lowest base first.
// ----------------------------------------------------------------------------
module ssk_seed_gather import ssk_pkg::*; #(
  parameter int SEED_WEIGHT = SEED_WEIGHT_DEF,
  parameter int NUM_SEEDS   = NUM_SEEDS_DEF,
  localparam int IDX_W      = 2 * SEED_WEIGHT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 go_i,
  input  logic [KMER_W-1:0]                    kmer_i,
  input  logic [NUM_SEEDS-1:0][MASK_W-1:0]     masks_i,
  output logic                                 done_o,
  output logic [NUM_SEEDS-1:0][IDX_W-1:0]      idx_o
);

  localparam int SLOT_W = $clog2(SEED_WEIGHT + 1);

  logic                               run_q;
  logic                               done_q;
  logic [STEP_W-1:0]                  step_q;
  logic [KMER_W-1:0]                  kmer_q;
  logic [NUM_SEEDS-1:0][IDX_W-1:0]    idx_q;
  logic [NUM_SEEDS-1:0][IDX_W-1:0]    idx_d;
  logic [NUM_SEEDS-1:0][SLOT_W-1:0]   slot_q;
  logic [NUM_SEEDS-1:0][SLOT_W-1:0]   slot_d;

  always_comb begin
    logic [STEP_W+1:0] pos;
    logic [1:0]        sym;
    idx_d  = idx_q;
    slot_d = slot_q;
    for (int s = 0; s < NUM_SEEDS; s++) begin
      for (int j = 0; j < BASES_PER_STEP; j++) begin
        pos = {step_q, 2'(j)};
        sym = kmer_q[{pos, 1'b0} +: 2];
        if (masks_i[s][pos] && (slot_d[s] < SLOT_W'(SEED_WEIGHT))) begin
          idx_d[s]  = idx_d[s] | (IDX_W'(sym) << {slot_d[s], 1'b0});
          slot_d[s] = slot_d[s] + SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= run_q && (step_q == STEP_W'(GATHER_STEPS - 1));
      if (go_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(GATHER_STEPS - 1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      kmer_q <= kmer_i;
      idx_q  <= '0;
      slot_q <= '0;
    end else if (run_q) begin
      idx_q  <= idx_d;
      slot_q <= slot_d;
    end
  end

  assign done_o = done_q;
  assign idx_o  = idx_q;

endmodule

@@ src/spaced_seed_kmer_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spaced_seed_kmer_filter
// Spaced-seed k-mer bit filter: inserts a k-mer into the per-seed bit table
// chosen by table_select and counts seed hits over all tables on query.
//
//   channel   ports                              handshake
//   input     start, busy, in_i                  taken when start & !busy
//   result    res_valid_o, res_o                 one-cycle strobe, no stall
//   config    cfg_we_i, cfg_addr_i, cfg_wdata_i  written when cfg_we_i
//
// An item passes through the symbol gather, walking 4 bases a cycle, then
// a table read and an apply step (insert write-back or hit count). One item
// is in flight at a time.
// After reset the tables are swept to zero, one 64-bit row per cycle over
// all 2^(2*SEED_WEIGHT-6) rows (16384 at default), busy high meanwhile.
// ----------------------------------------------------------------------------
module spaced_seed_kmer_filter import ssk_pkg::*; #(
  parameter int SEED_WEIGHT = SEED_WEIGHT_DEF,
  parameter int NUM_SEEDS   = NUM_SEEDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  kmer_item_t            in_i,
  output logic                  res_valid_o,
  output hit_result_t           res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int IDX_W  = 2 * SEED_WEIGHT;
  localparam int ROW_AW = IDX_W - BIT_AW;
  localparam int ROWS   = 2 ** ROW_AW;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GATHER,
    ST_APPLY
  } state_e;

  state_e                            state_q;
  logic [ROW_AW-1:0]                 clr_cnt_q;
  logic                              res_valid_q;
  hit_result_t                       res_q;
  cmd_e                              cmd_q;
  logic [SEL_W-1:0]                  sel_q;

  logic [MASK_W-1:0]                 mask_q [NUM_MASK_REGS];
  logic [THR_W-1:0]                  thr_q;

  logic                              go;
  logic                              gather_done;
  logic [NUM_SEEDS-1:0][MASK_W-1:0]  lane_mask;
  logic [NUM_SEEDS-1:0][IDX_W-1:0]   lane_idx;
  logic [NUM_SEEDS-1:0]              hit;
  logic                              rd_en;
  logic [3:0]                        hit_sum;
  logic [HIT_W-1:0]                  hit_cnt;

  assign busy = (state_q != ST_IDLE);
  assign go   = start && !busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MASK_REGS; i++) begin
        mask_q[i] <= '0;
      end
      thr_q <= THR_W'(3);
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_THRESHOLD) begin
        thr_q <= cfg_wdata_i[THR_W-1:0];
      end else if (cfg_addr_i < REG_THRESHOLD) begin
        mask_q[cfg_addr_i] <= cfg_wdata_i[MASK_W-1:0];
      end
    end
  end

  for (genvar s = 0; s < NUM_SEEDS; s++) begin : g_mask
    if (s < NUM_MASK_REGS) begin : g_reg
      assign lane_mask[s] = mask_q[s];
    end else begin : g_zero
      assign lane_mask[s] = '0;
    end
  end

  ssk_seed_gather #(
    .SEED_WEIGHT (SEED_WEIGHT),
    .NUM_SEEDS   (NUM_SEEDS)
  ) u_gather (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (go),
    .kmer_i  (in_i.kmer),
    .masks_i (lane_mask),
    .done_o  (gather_done),
    .idx_o   (lane_idx)
  );

  assign rd_en = (state_q == ST_GATHER) && gather_done;

  // one bit table per seed, stored as 64-bit rows
  for (genvar s = 0; s < NUM_SEEDS; s++) begin : g_table
    logic [ROW_W-1:0]  mem [ROWS];
    logic [ROW_W-1:0]  rd_q;
    logic              we;
    logic [ROW_AW-1:0] waddr;
    logic [ROW_W-1:0]  wdata;

    always_comb begin
      if (state_q == ST_CLEAR) begin
        we    = 1'b1;
        waddr = clr_cnt_q;
        wdata = '0;
      end else begin
        we    = (state_q == ST_APPLY) && (cmd_q == CMD_INSERT) && (sel_q == SEL_W'(s));
        waddr = lane_idx[s][IDX_W-1:BIT_AW];
        wdata = rd_q | (ROW_W'(1) << lane_idx[s][BIT_AW-1:0]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      if (rd_en) begin
        rd_q <= mem[lane_idx[s][IDX_W-1:BIT_AW]];
      end
    end

    assign hit[s] = rd_q[lane_idx[s][BIT_AW-1:0]];
  end

  always_comb begin
    hit_sum = '0;
    for (int s = 0; s < NUM_SEEDS; s++) begin
      hit_sum = hit_sum + 4'(hit[s]);
    end
    hit_cnt = (hit_sum > 4'(HIT_MAX)) ? HIT_W'(HIT_MAX) : hit_sum[HIT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      cmd_q       <= CMD_INSERT;
      sel_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + ROW_AW'(1);
          if (clr_cnt_q == ROW_AW'(ROWS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            cmd_q   <= in_i.command;
            sel_q   <= in_i.table_select;
            state_q <= ST_GATHER;
          end
        end
        ST_GATHER: begin
          if (gather_done) begin
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (cmd_q == CMD_QUERY) begin
            res_valid_q     <= 1'b1;
            res_q.hit_count <= hit_cnt;
            res_q.present   <= (hit_cnt > HIT_W'(thr_q));
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
